// File: design/ppt_pkg.sv
package ppt_pkg;

    localparam int PPT_MAX_EXPONENT = 32;
    localparam int PPT_VALUE_BITS   = 31;

    localparam int PC_W   = 4;
    localparam int OP_W   = 4;
    localparam int COND_W = 4;

    // datapath operations
    localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 4'd1;
    localparam logic [OP_W-1:0] OP_SMALL   = 4'd2;
    localparam logic [OP_W-1:0] OP_SQRT    = 4'd3;
    localparam logic [OP_W-1:0] OP_INIT    = 4'd4;
    localparam logic [OP_W-1:0] OP_PROBE   = 4'd5;
    localparam logic [OP_W-1:0] OP_MULACC  = 4'd6;
    localparam logic [OP_W-1:0] OP_SHIFT   = 4'd7;
    localparam logic [OP_W-1:0] OP_MULBASE = 4'd8;
    localparam logic [OP_W-1:0] OP_UPDATE  = 4'd9;
    localparam logic [OP_W-1:0] OP_DONE    = 4'd10;

    // jump conditions
    localparam logic [COND_W-1:0] C_NEVER   = 4'd0;
    localparam logic [COND_W-1:0] C_ALWAYS  = 4'd1;
    localparam logic [COND_W-1:0] C_NOSTART = 4'd2;
    localparam logic [COND_W-1:0] C_XLE1    = 4'd3;
    localparam logic [COND_W-1:0] C_SQMORE  = 4'd4;
    localparam logic [COND_W-1:0] C_LOGTHI  = 4'd5;
    localparam logic [COND_W-1:0] C_POWDONE = 4'd6;
    localparam logic [COND_W-1:0] C_EXPEVEN = 4'd7;
    localparam logic [COND_W-1:0] C_MULMORE = 4'd8;
    localparam logic [COND_W-1:0] C_EXPLE1  = 4'd9;
    localparam logic [COND_W-1:0] C_PEQ     = 4'd10;

    // program steps
    localparam logic [PC_W-1:0] S_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] S_SMALL    = 4'd1;
    localparam logic [PC_W-1:0] S_SQRT     = 4'd2;
    localparam logic [PC_W-1:0] S_INIT     = 4'd3;
    localparam logic [PC_W-1:0] S_LOOP     = 4'd4;
    localparam logic [PC_W-1:0] S_PROBE    = 4'd5;
    localparam logic [PC_W-1:0] S_POWTEST  = 4'd6;
    localparam logic [PC_W-1:0] S_ODD      = 4'd7;
    localparam logic [PC_W-1:0] S_MULACC   = 4'd8;
    localparam logic [PC_W-1:0] S_SHIFT    = 4'd9;
    localparam logic [PC_W-1:0] S_MULBASE  = 4'd10;
    localparam logic [PC_W-1:0] S_BACK     = 4'd11;
    localparam logic [PC_W-1:0] S_UPDATE   = 4'd12;
    localparam logic [PC_W-1:0] S_NEXT     = 4'd13;
    localparam logic [PC_W-1:0] S_DONE     = 4'd14;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } ctrl_t;

    // taken jump goes to target, otherwise fall through to the next step
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t cw;
        case (pc)
            S_IDLE:    cw = '{OP_LOAD,    C_NOSTART, S_IDLE};
            S_SMALL:   cw = '{OP_SMALL,   C_XLE1,    S_DONE};
            S_SQRT:    cw = '{OP_SQRT,    C_SQMORE,  S_SQRT};
            S_INIT:    cw = '{OP_INIT,    C_NEVER,   S_IDLE};
            S_LOOP:    cw = '{OP_NOP,     C_LOGTHI,  S_DONE};
            S_PROBE:   cw = '{OP_PROBE,   C_NEVER,   S_IDLE};
            S_POWTEST: cw = '{OP_NOP,     C_POWDONE, S_UPDATE};
            S_ODD:     cw = '{OP_NOP,     C_EXPEVEN, S_SHIFT};
            S_MULACC:  cw = '{OP_MULACC,  C_MULMORE, S_MULACC};
            S_SHIFT:   cw = '{OP_SHIFT,   C_EXPLE1,  S_POWTEST};
            S_MULBASE: cw = '{OP_MULBASE, C_MULMORE, S_MULBASE};
            S_BACK:    cw = '{OP_NOP,     C_ALWAYS,  S_POWTEST};
            S_UPDATE:  cw = '{OP_UPDATE,  C_PEQ,     S_DONE};
            S_NEXT:    cw = '{OP_NOP,     C_ALWAYS,  S_LOOP};
            S_DONE:    cw = '{OP_DONE,    C_ALWAYS,  S_IDLE};
            default:   cw = '{OP_NOP,     C_ALWAYS,  S_IDLE};
        endcase
        return cw;
    endfunction

endpackage

// File: design/perfect_power_test.sv
// Values 0 and 1 are decided directly; any other value first gets its integer square root,
// two value bits per step, then a binary search over bases 2 to that root runs one probe
// per guess, raising it to the exponent bit by bit on the one shared multiplier; a saturated
// power ends a probe early.
// Throughput: one item at a time; busy stays high until done, next start taken in the done cycle;
// done cannot be held off. Reset (rst_n, asynchronous) idles the sequencer; no clearing pass.
module perfect_power_test
    import ppt_pkg::*;
#(
    parameter int MAX_EXPONENT = PPT_MAX_EXPONENT,
    parameter int VALUE_BITS   = PPT_VALUE_BITS,
    localparam int EXP_W       = $clog2(MAX_EXPONENT + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [EXP_W-1:0]      exponent,
    output logic                  busy,
    output logic                  done,
    output logic                  is_power
);

    localparam int VB    = VALUE_BITS;
    localparam int SQ    = (VB + 1) / 2;
    localparam int SQX_W = 2 * SQ;
    localparam int REM_W = SQ + 2;
    localparam int RSH_W = SQ + 4;
    localparam int RW    = SQ + 1;
    localparam int SQC_W = $clog2(SQ);
    localparam int NP    = (VB > 32) ? 2 : 1;
    localparam int CW    = (VB + NP - 1) / NP;
    localparam int AW    = NP * CW;
    localparam int PW    = 2 * AW;
    localparam int PPW   = (NP == 2) ? 2 : 1;
    localparam int PP_LAST = NP * NP - 1;

    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [PPW-1:0]   pp_reg;
    logic             done_reg;

    logic [VB-1:0]    x_reg;
    logic [EXP_W-1:0] n_reg;
    logic [EXP_W-1:0] exp_reg;
    logic [SQX_W-1:0] sqx_reg;
    logic [REM_W-1:0] rem_reg;
    logic [SQ-1:0]    root_reg;
    logic [SQC_W-1:0] sqcnt_reg;
    logic [RW-1:0]    lo_reg;
    logic [RW-1:0]    hi_reg;
    logic [SQ-1:0]    guess_reg;
    logic [VB-1:0]    base_reg;
    logic             base_sat_reg;
    logic [VB-1:0]    acc_reg;
    logic             acc_sat_reg;
    logic [PW-1:0]    prod_reg;
    logic             res_reg;

    ctrl_t            cw;
    logic             jump;

    logic [RSH_W-1:0] rem_sh;
    logic [RSH_W-1:0] trial;
    logic             sq_ge;
    logic [REM_W-1:0] rem_new;
    logic [SQ-1:0]    root_new;

    logic [RW-1:0]    mid;

    logic [AW-1:0]    a_ext;
    logic [AW-1:0]    b_ext;
    logic             ia;
    logic             jb;
    logic [CW-1:0]    a_chunk;
    logic [CW-1:0]    b_chunk;
    logic [2*CW-1:0]  partial;
    logic [PW-1:0]    term;
    logic [PW-1:0]    mul_sum;
    logic             mul_ovf;
    logic             mul_last;

    logic             p_big;
    logic             p_less;

    assign cw = ucode(pc_reg);

    // root bound, two bits of the value per step
    assign rem_sh   = {rem_reg, sqx_reg[SQX_W-1 -: 2]};
    assign trial    = RSH_W'({root_reg, 2'b01});
    assign sq_ge    = rem_sh >= trial;
    assign rem_new  = sq_ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
    assign root_new = {root_reg[SQ-2:0], sq_ge};

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // shared multiplier, NP x NP partial products accumulated in turn
    assign a_ext    = AW'((cw.op == OP_MULACC) ? acc_reg : base_reg);
    assign b_ext    = AW'(base_reg);
    assign ia       = (NP == 2) ? pp_reg[0] : 1'b0;
    assign jb       = (NP == 2) ? pp_reg[PPW-1] : 1'b0;
    assign a_chunk  = CW'(a_ext >> (ia ? CW : 0));
    assign b_chunk  = CW'(b_ext >> (jb ? CW : 0));
    assign partial  = (2*CW)'(a_chunk) * (2*CW)'(b_chunk);
    assign term     = PW'(partial) << ((ia ? CW : 0) + (jb ? CW : 0));
    assign mul_sum  = ((pp_reg == '0) ? '0 : prod_reg) + term;
    assign mul_ovf  = |(mul_sum >> VB);
    assign mul_last = pp_reg == PPW'(PP_LAST);

    assign p_big  = acc_sat_reg || base_sat_reg || (acc_reg > x_reg);
    assign p_less = !p_big && (acc_reg < x_reg);

    always_comb
    begin
        case (cw.cond)
            C_NEVER:   jump = 1'b0;
            C_ALWAYS:  jump = 1'b1;
            C_NOSTART: jump = !start;
            C_XLE1:    jump = x_reg <= VB'(1);
            C_SQMORE:  jump = sqcnt_reg != SQC_W'(SQ - 1);
            C_LOGTHI:  jump = lo_reg > hi_reg;
            C_POWDONE: jump = (exp_reg == '0) || acc_sat_reg || base_sat_reg;
            C_EXPEVEN: jump = !exp_reg[0];
            C_MULMORE: jump = !mul_last;
            C_EXPLE1:  jump = exp_reg <= EXP_W'(1);
            C_PEQ:     jump = !p_big && !p_less;
            default:   jump = 1'b0;
        endcase
        pc_next = jump ? cw.target : pc_reg + PC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= S_IDLE;
            pp_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            done_reg <= cw.op == OP_DONE;
            if (cw.op == OP_MULACC || cw.op == OP_MULBASE)
            begin
                pp_reg <= mul_last ? '0 : pp_reg + PPW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cw.op)
            OP_LOAD:
            begin
                x_reg     <= value;
                n_reg     <= exponent;
                sqx_reg   <= SQX_W'(value);
                rem_reg   <= '0;
                root_reg  <= '0;
                sqcnt_reg <= '0;
            end
            OP_SMALL:
            begin
                res_reg <= x_reg == VB'(1);
            end
            OP_SQRT:
            begin
                rem_reg   <= rem_new;
                root_reg  <= root_new;
                sqx_reg   <= sqx_reg << 2;
                sqcnt_reg <= sqcnt_reg + SQC_W'(1);
            end
            OP_INIT:
            begin
                lo_reg  <= RW'(2);
                hi_reg  <= RW'(root_reg);
                res_reg <= 1'b0;
            end
            OP_PROBE:
            begin
                guess_reg    <= mid[SQ-1:0];
                base_reg     <= VB'(mid[SQ-1:0]);
                base_sat_reg <= 1'b0;
                acc_reg      <= VB'(1);
                acc_sat_reg  <= 1'b0;
                exp_reg      <= n_reg;
            end
            OP_MULACC:
            begin
                prod_reg <= mul_sum;
                if (mul_last)
                begin
                    acc_reg     <= VB'(mul_sum);
                    acc_sat_reg <= mul_ovf;
                end
            end
            OP_SHIFT:
            begin
                exp_reg <= exp_reg >> 1;
            end
            OP_MULBASE:
            begin
                prod_reg <= mul_sum;
                if (mul_last)
                begin
                    base_reg     <= VB'(mul_sum);
                    base_sat_reg <= mul_ovf;
                end
            end
            OP_UPDATE:
            begin
                if (p_big)
                begin
                    hi_reg <= RW'(guess_reg) - RW'(1);
                end
                else if (p_less)
                begin
                    lo_reg <= RW'(guess_reg) + RW'(1);
                end
                else
                begin
                    res_reg <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign busy     = pc_reg != S_IDLE;
    assign done     = done_reg;
    assign is_power = res_reg;

endmodule
